### rtl/core/matrix_stack_vertex_transform_defines.svh
// assertion macros for the matrix stack vertex transform block
// depends on nothing; the asserting module must have clock and reset signals
`ifndef MATRIX_STACK_VERTEX_TRANSFORM_DEFINES_SVH
`define MATRIX_STACK_VERTEX_TRANSFORM_DEFINES_SVH
`ifndef SYNTHESIS
`define MSVT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define MSVT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);
`else
`define MSVT_ASSERT(label, prop, msg)
`define MSVT_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### rtl/core/msvt_pkg.sv
// shared types, codes and constants of the matrix stack vertex transform block
// depends on nothing
package msvt_pkg;

   localparam int STACK_DEPTH  = 20;
   localparam int CORDIC_STEPS = 16;
   localparam int CNT_W        = $clog2(STACK_DEPTH + 1);
   localparam int RAM_DEPTH    = STACK_DEPTH * 16;
   localparam int RAM_AW       = $clog2(RAM_DEPTH);
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   localparam logic [2:0] KIND_XFORM  = 3'd0;
   localparam logic [2:0] KIND_PUSH   = 3'd1;
   localparam logic [2:0] KIND_POP    = 3'd2;
   localparam logic [2:0] KIND_SCALE  = 3'd3;
   localparam logic [2:0] KIND_ROTATE = 3'd4;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_OVF = 2'd1;
   localparam logic [1:0] ST_UNF = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic signed [31:0] ONE_Q16         = 32'sd65536;
   localparam logic [32:0]        FULL_TURN_Q16   = 33'd23592960;
   localparam logic [32:0]        QUARTER_Q16     = 33'd5898240;
   localparam logic signed [33:0] TURN_BIAS       = 34'sd2170552320;
   localparam logic [26:0]        DEG_TO_RAD_Q32  = 27'd74961321;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [65:0] SAT_MAX         = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN         = -66'sd2147483648;

   typedef enum logic [2:0] {
      OP_NOP, OP_XFORM, OP_PUSH, OP_POP, OP_SCALE, OP_ROTATE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] comp0;
      logic signed [31:0] comp1;
      logic signed [31:0] comp2;
      logic signed [31:0] comp3;
      logic [32:0]        angle_ofs;
      logic [1:0]         axis;
      logic               last;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_type;

   typedef struct packed {
      logic        start;
      logic [32:0] angle;
   } cordic_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] sin;
      logic signed [31:0] cos;
   } cordic_rsp_type;

   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/msvt_if.sv
// command and result channel interfaces, valid/ready handshake
// depends on nothing
interface msvt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [31:0] comp0;
   logic signed [31:0] comp1;
   logic signed [31:0] comp2;
   logic signed [31:0] comp3;
   logic signed [31:0] angle_deg;
   logic [1:0]         axis;
   logic               batch_end;

   modport source (output valid, kind, comp0, comp1, comp2, comp3, angle_deg, axis,
                   batch_end, input ready);
   modport sink (input valid, kind, comp0, comp1, comp2, comp3, angle_deg, axis,
                 batch_end, output ready);
endinterface

interface msvt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res0;
   logic signed [31:0] res1;
   logic signed [31:0] res2;
   logic signed [31:0] res3;
   logic [1:0]         status;
   logic               last_out;

   modport source (output valid, res0, res1, res2, res3, status, last_out, input ready);
   modport sink (input valid, res0, res1, res2, res3, status, last_out, output ready);
endinterface

### rtl/core/msvt_ram.sv
// generic ram with separate write and read addresses and registered read
// depends on nothing
module msvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end
endmodule

### rtl/core/msvt_cordic.sv
// angle reduction and rotation-mode cordic giving sin and cos in q16.16
// depends on msvt_pkg
module msvt_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  msvt_pkg::cordic_req_type creq,
   output msvt_pkg::cordic_rsp_type crsp
);
   import msvt_pkg::*;

   localparam logic [2:0] CS_IDLE   = 3'd0;
   localparam logic [2:0] CS_REDUCE = 3'd1;
   localparam logic [2:0] CS_QUAD   = 3'd2;
   localparam logic [2:0] CS_SCALE  = 3'd3;
   localparam logic [2:0] CS_ITER   = 3'd4;
   localparam logic [2:0] CS_FINISH = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         k_ff, k_in;
   logic [STEP_W-1:0]  i_ff, i_in;
   logic [32:0]        a_ff, a_in;
   logic [32:0]        turn_sub;
   logic [1:0]         q_ff, q_in;
   logic [22:0]        r_ff, r_in;
   logic [49:0]        prod;
   logic signed [33:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [33:0] dx, dy, at, cr, sr;
   logic signed [31:0] c32, s32;
   logic signed [31:0] sin_ff, sin_in, cos_ff, cos_in;
   logic               done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      i_in     = i_ff;
      a_in     = a_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      sin_in   = sin_ff;
      cos_in   = cos_ff;
      done_in  = 1'b0;
      turn_sub = FULL_TURN_Q16 << k_ff;
      prod     = 50'(r_ff) * 50'(DEG_TO_RAD_Q32);
      dx       = y_ff >>> i_ff;
      dy       = x_ff >>> i_ff;
      at       = signed'({4'b0, atan_q30(5'(i_ff))});
      cr       = (x_ff + 34'sd8192) >>> 14;
      sr       = (y_ff + 34'sd8192) >>> 14;
      c32      = 32'(cr);
      s32      = 32'(sr);
      case (state_ff)
         CS_IDLE: begin
            if (creq.start) begin
               a_in     = creq.angle;
               k_in     = 3'd7;
               state_in = CS_REDUCE;
            end
         end
         CS_REDUCE: begin
            if (a_ff >= turn_sub) begin
               a_in = a_ff - turn_sub;
            end
            k_in = k_ff - 3'd1;
            if (k_ff == 3'd0) begin
               state_in = CS_QUAD;
            end
         end
         CS_QUAD: begin
            if (a_ff >= 3 * QUARTER_Q16) begin
               q_in = 2'd3;
               r_in = 23'(a_ff - 3 * QUARTER_Q16);
            end else if (a_ff >= 2 * QUARTER_Q16) begin
               q_in = 2'd2;
               r_in = 23'(a_ff - 2 * QUARTER_Q16);
            end else if (a_ff >= QUARTER_Q16) begin
               q_in = 2'd1;
               r_in = 23'(a_ff - QUARTER_Q16);
            end else begin
               q_in = 2'd0;
               r_in = 23'(a_ff);
            end
            state_in = CS_SCALE;
         end
         CS_SCALE: begin
            z_in     = signed'(34'((prod + 50'd131072) >> 18));
            x_in     = CORDIC_GAIN_Q30;
            y_in     = '0;
            i_in     = '0;
            state_in = CS_ITER;
         end
         CS_ITER: begin
            if (!z_ff[33]) begin
               x_in = x_ff - dx;
               y_in = y_ff + dy;
               z_in = z_ff - at;
            end else begin
               x_in = x_ff + dx;
               y_in = y_ff - dy;
               z_in = z_ff + at;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = CS_FINISH;
            end
         end
         CS_FINISH: begin
            case (q_ff)
               2'd0: begin
                  cos_in = c32;
                  sin_in = s32;
               end
               2'd1: begin
                  cos_in = -s32;
                  sin_in = c32;
               end
               2'd2: begin
                  cos_in = -c32;
                  sin_in = -s32;
               end
               default: begin
                  cos_in = s32;
                  sin_in = -c32;
               end
            endcase
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      k_ff   <= k_in;
      i_ff   <= i_in;
      a_ff   <= a_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign crsp.done = done_ff;
   assign crsp.sin  = sin_ff;
   assign crsp.cos  = cos_ff;
endmodule

### rtl/core/msvt_front.sv
// command intake: decodes each transaction and queues it for the back end
// depends on msvt_pkg and msvt_if
module msvt_front (
   input  logic                clock,
   input  logic                reset,
   msvt_req_if.sink            req,
   output msvt_pkg::queue_type qout,
   input  logic                q_pop
);
   import msvt_pkg::*;

   cmd_type            fifo_ff [2];
   cmd_type            cmd;
   logic [1:0]         cnt_ff, cnt_in;
   logic               wr_ff, wr_in, rd_ff, rd_in;
   logic               push;
   logic signed [33:0] ang_sum;

   always_comb begin
      ang_sum       = 34'(req.angle_deg) + TURN_BIAS;
      cmd.comp0     = req.comp0;
      cmd.comp1     = req.comp1;
      cmd.comp2     = req.comp2;
      cmd.comp3     = req.comp3;
      cmd.angle_ofs = ang_sum[32:0];
      cmd.axis      = req.axis;
      cmd.last      = req.batch_end;
      case (req.kind)
         KIND_XFORM:  cmd.op = OP_XFORM;
         KIND_PUSH:   cmd.op = OP_PUSH;
         KIND_POP:    cmd.op = OP_POP;
         KIND_SCALE:  cmd.op = OP_SCALE;
         KIND_ROTATE: cmd.op = OP_ROTATE;
         default:     cmd.op = OP_NOP;
      endcase
   end

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign qout.valid = (cnt_ff != 2'd0);
   assign qout.cmd   = fifo_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
      if (push) begin
         fifo_ff[wr_ff] <= cmd;
      end
   end
endmodule

### rtl/core/msvt_back.sv
// command execution: 4-multiplier dot product pipeline, matrix state and stack
// depends on msvt_pkg, msvt_if, msvt_ram and the assertion macro header
`include "matrix_stack_vertex_transform_defines.svh"
module msvt_back (
   input  logic                      clock,
   input  logic                      reset,
   input  msvt_pkg::queue_type       qin,
   output logic                      q_pop,
   output msvt_pkg::cordic_req_type  creq,
   input  msvt_pkg::cordic_rsp_type  crsp,
   msvt_rsp_if.source                rsp
);
   import msvt_pkg::*;

   localparam logic [3:0] B_IDLE   = 4'd0;
   localparam logic [3:0] B_MUL    = 4'd1;
   localparam logic [3:0] B_DRAIN  = 4'd2;
   localparam logic [3:0] B_PUSH   = 4'd3;
   localparam logic [3:0] B_POP    = 4'd4;
   localparam logic [3:0] B_POPW   = 4'd5;
   localparam logic [3:0] B_ROT    = 4'd6;
   localparam logic [3:0] B_COMMIT = 4'd7;
   localparam logic [3:0] B_DONE   = 4'd8;

   logic [3:0]         state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [1:0]         st_ff, st_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [3:0]         idx_ff, idx_in;
   logic               mul_last;

   logic signed [31:0] m_ff [4][4];
   logic signed [31:0] n_ff [4][4];
   logic signed [31:0] d_ff [4][4];
   logic signed [31:0] d_in [4][4];
   logic               d_ld;

   logic signed [31:0] vin [4];
   logic signed [31:0] opa [4];
   logic signed [31:0] opm [4];
   logic signed [63:0] prod_ff [4];
   logic               p_vld_ff;
   logic [3:0]         p_idx_ff;
   logic signed [65:0] sum_in, sum_ff, rnd;
   logic               s_vld_ff;
   logic [3:0]         s_idx_ff;
   logic signed [31:0] sat;
   logic signed [31:0] r_ff [4];

   logic               ram_we;
   logic [RAM_AW-1:0]  ram_addr;
   logic [31:0]        ram_rdata;
   logic               pr_vld_ff;
   logic [3:0]         pr_idx_ff;

   logic               out_vld_ff, out_vld_in, out_ld;
   logic signed [31:0] ores_ff [4];
   logic [1:0]         ost_ff;
   logic               olast_ff;

   assign mul_last = (cmd_ff.op == OP_XFORM) ? (idx_ff == 4'd3) : (idx_ff == 4'd15);

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      st_in      = st_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      q_pop      = 1'b0;
      creq.start = 1'b0;
      creq.angle = cmd_ff.angle_ofs;
      out_ld     = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (qin.valid) begin
               q_pop  = 1'b1;
               cmd_in = qin.cmd;
               st_in  = ST_OK;
               idx_in = '0;
               case (qin.cmd.op)
                  OP_XFORM, OP_SCALE: state_in = B_MUL;
                  OP_PUSH: begin
                     if (cnt_ff == CNT_W'(STACK_DEPTH)) begin
                        st_in    = ST_OVF;
                        state_in = B_DONE;
                     end else begin
                        state_in = B_PUSH;
                     end
                  end
                  OP_POP: begin
                     if (cnt_ff == '0) begin
                        st_in    = ST_UNF;
                        state_in = B_DONE;
                     end else begin
                        cnt_in   = cnt_ff - 1'b1;
                        state_in = B_POP;
                     end
                  end
                  OP_ROTATE: begin
                     creq.start = 1'b1;
                     creq.angle = qin.cmd.angle_ofs;
                     state_in   = B_ROT;
                  end
                  default: state_in = B_DONE;
               endcase
            end
         end
         B_MUL: begin
            idx_in = idx_ff + 4'd1;
            if (mul_last) begin
               idx_in   = '0;
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!p_vld_ff && !s_vld_ff) begin
               state_in = (cmd_ff.op == OP_XFORM) ? B_DONE : B_COMMIT;
            end
         end
         B_PUSH: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = B_DONE;
            end
         end
         B_POP: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               state_in = B_POPW;
            end
         end
         B_POPW:   state_in = B_DONE;
         B_ROT: begin
            if (crsp.done) begin
               state_in = B_MUL;
            end
         end
         B_COMMIT: state_in = B_DONE;
         B_DONE: begin
            if (!out_vld_ff || rsp.ready) begin
               out_ld   = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // operand matrix for scale or rotate
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            d_in[i][j] = (i == j) ? ONE_Q16 : '0;
         end
      end
      if (state_ff == B_ROT) begin
         case (cmd_ff.axis)
            AXIS_X: begin
               d_in[1][1] = crsp.cos;
               d_in[1][2] = crsp.sin;
               d_in[2][1] = -crsp.sin;
               d_in[2][2] = crsp.cos;
            end
            AXIS_Y: begin
               d_in[0][0] = crsp.cos;
               d_in[0][2] = -crsp.sin;
               d_in[2][0] = crsp.sin;
               d_in[2][2] = crsp.cos;
            end
            AXIS_Z: begin
               d_in[0][0] = crsp.cos;
               d_in[0][1] = crsp.sin;
               d_in[1][0] = -crsp.sin;
               d_in[1][1] = crsp.cos;
            end
            default: ;
         endcase
      end else begin
         d_in[0][0] = qin.cmd.comp0;
         d_in[1][1] = qin.cmd.comp1;
         d_in[2][2] = qin.cmd.comp2;
      end
   end

   assign d_ld = (state_ff == B_IDLE && qin.valid && qin.cmd.op == OP_SCALE) ||
                 (state_ff == B_ROT && crsp.done);

   assign vin[0] = cmd_ff.comp0;
   assign vin[1] = cmd_ff.comp1;
   assign vin[2] = cmd_ff.comp2;
   assign vin[3] = cmd_ff.comp3;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         opa[k] = (cmd_ff.op == OP_XFORM) ? vin[k] : d_ff[idx_ff[3:2]][k];
         opm[k] = m_ff[k][idx_ff[1:0]];
      end
      sum_in = 66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2]) + 66'(prod_ff[3]);
      rnd    = (sum_ff + 66'sd32768) >>> 16;
      if (rnd > SAT_MAX) begin
         sat = 32'sh7fffffff;
      end else if (rnd < SAT_MIN) begin
         sat = 32'sh80000000;
      end else begin
         sat = rnd[31:0];
      end
   end

   assign ram_we   = (state_ff == B_PUSH);
   assign ram_addr = RAM_AW'({cnt_ff, idx_ff});

   msvt_ram #(
      .WIDTH (32),
      .DEPTH (RAM_DEPTH)
   ) u_stack (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_addr),
      .wdata (m_ff[idx_ff[3:2]][idx_ff[1:0]]),
      .raddr (ram_addr),
      .rdata (ram_rdata)
   );

   assign out_vld_in = out_ld || (out_vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         cnt_ff     <= '0;
         p_vld_ff   <= 1'b0;
         s_vld_ff   <= 1'b0;
         pr_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               m_ff[i][j] <= (i == j) ? ONE_Q16 : '0;
            end
         end
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         p_vld_ff   <= (state_ff == B_MUL);
         s_vld_ff   <= p_vld_ff;
         pr_vld_ff  <= (state_ff == B_POP);
         out_vld_ff <= out_vld_in;
         if (pr_vld_ff) begin
            m_ff[pr_idx_ff[3:2]][pr_idx_ff[1:0]] <= signed'(ram_rdata);
         end else if (state_ff == B_COMMIT) begin
            m_ff <= n_ff;
         end
      end
      cmd_ff    <= cmd_in;
      st_ff     <= st_in;
      idx_ff    <= idx_in;
      p_idx_ff  <= idx_ff;
      s_idx_ff  <= p_idx_ff;
      pr_idx_ff <= idx_ff;
      sum_ff    <= sum_in;
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= opa[k] * opm[k];
      end
      if (d_ld) begin
         d_ff <= d_in;
      end
      if (s_vld_ff) begin
         if (cmd_ff.op == OP_XFORM) begin
            r_ff[s_idx_ff[1:0]] <= sat;
         end else begin
            n_ff[s_idx_ff[3:2]][s_idx_ff[1:0]] <= sat;
         end
      end
      if (out_ld) begin
         for (int k = 0; k < 4; k++) begin
            ores_ff[k] <= (cmd_ff.op == OP_XFORM) ? r_ff[k] : '0;
         end
         ost_ff   <= st_ff;
         olast_ff <= cmd_ff.last;
      end
   end

   assign rsp.valid    = out_vld_ff;
   assign rsp.res0     = ores_ff[0];
   assign rsp.res1     = ores_ff[1];
   assign rsp.res2     = ores_ff[2];
   assign rsp.res3     = ores_ff[3];
   assign rsp.status   = ost_ff;
   assign rsp.last_out = olast_ff;

   `MSVT_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(STACK_DEPTH), "stack count beyond depth")
   `MSVT_ASSERT(a_ovf_full, (state_ff == B_DONE && st_ff == ST_OVF) |-> (cnt_ff == CNT_W'(STACK_DEPTH)), "overflow on a stack that is not full")
   `MSVT_ASSERT(a_err_zero, (out_vld_ff && ost_ff != ST_OK) |-> (ores_ff[0] == 0 && ores_ff[1] == 0 && ores_ff[2] == 0 && ores_ff[3] == 0), "stack error result with nonzero vertex")
   `MSVT_ASSERT_NEXT(a_pop_busy, q_pop, state_ff != B_IDLE, "dequeued transaction not started")
endmodule

### rtl/core/matrix_stack_vertex_transform.sv
// top level: vertex transform with a 4x4 q16.16 matrix and a push/pop matrix stack
// transform: dot products on the 4-multiplier pipe; one transaction is finished before the next is taken
// scale and rotate compose a new matrix of 16 entries; rotate first runs a cordic of 16 steps
// push and pop move one stack ram word per cycle
// synchronous reset sets the identity matrix and an empty stack; no clearing pass
module matrix_stack_vertex_transform (
   input logic        clock,
   input logic        reset,
   msvt_req_if.sink   req_chan,
   msvt_rsp_if.source rsp_chan
);
   import msvt_pkg::*;

   queue_type      queue;
   logic           q_pop;
   cordic_req_type creq;
   cordic_rsp_type crsp;

   msvt_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .qout  (queue),
      .q_pop (q_pop)
   );

   msvt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .creq  (creq),
      .crsp  (crsp)
   );

   msvt_back u_back (
      .clock (clock),
      .reset (reset),
      .qin   (queue),
      .q_pop (q_pop),
      .creq  (creq),
      .crsp  (crsp),
      .rsp   (rsp_chan)
   );
endmodule

### bench/msvt_bench_pkg.sv
// predictor of the matrix stack vertex transform block: q16.16 matrix, stack, cordic
// depends on msvt_pkg for the command kinds, status codes, axes and constants
package msvt_bench_pkg;
   import msvt_pkg::*;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] comp[4];
      logic signed [31:0] angle_deg;
      logic [1:0]         axis;
      logic               batch_end;
   } command_t;

   typedef struct {
      logic signed [31:0] res[4];
      logic [1:0]         status;
      logic               last_out;
   } vertex_out_t;

   localparam longint ATAN_TAB[32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
      16, 8, 4, 2, 1, 0};

   class transform_predictor;
      logic signed [31:0] cur[16];
      logic signed [31:0] saved[STACK_DEPTH * 16];
      int unsigned        depth_used;

      function void clear();
         for (int i = 0; i < 16; i++) cur[i] = (i % 5 == 0) ? ONE_Q16 : 32'sd0;
         depth_used = 0;
      endfunction

      static function logic signed [31:0] dot_col(logic signed [31:0] a[4],
                                                  logic signed [31:0] m[16], int col);
         logic signed [127:0] acc;
         acc = 0;
         for (int k = 0; k < 4; k++) acc += 128'(a[k]) * 128'(m[k * 4 + col]);
         acc = (acc + 128'sd32768) >>> 16;
         if (acc > 128'sd2147483647) return 32'h7fffffff;
         if (acc < -128'sd2147483648) return 32'h80000000;
         return acc[31:0];
      endfunction

      function void compose(logic signed [31:0] d[16]);
         logic signed [31:0] row[4];
         logic signed [31:0] nxt[16];
         for (int i = 0; i < 4; i++) begin
            for (int k = 0; k < 4; k++) row[k] = d[i * 4 + k];
            for (int j = 0; j < 4; j++) nxt[i * 4 + j] = dot_col(row, cur, j);
         end
         cur = nxt;
      endfunction

      static function void sin_cos(logic signed [31:0] deg, output logic signed [31:0] s,
                                   output logic signed [31:0] c);
         longint m, q, r, x, y, z, dx, dy;
         logic signed [31:0] cc, ss;
         m = longint'(deg) % 23592960;
         if (m < 0) m += 23592960;
         q = m / 5898240;
         r = m - q * 5898240;
         z = (r * 74961321 + 131072) >>> 18;
         x = 652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= ATAN_TAB[i];
            end else begin
               x += dx; y -= dy; z += ATAN_TAB[i];
            end
         end
         cc = 32'((x + 8192) >>> 14);
         ss = 32'((y + 8192) >>> 14);
         case (q)
            0: begin c = cc; s = ss; end
            1: begin c = -ss; s = cc; end
            2: begin c = -cc; s = -ss; end
            default: begin c = ss; s = -cc; end
         endcase
      endfunction

      function vertex_out_t apply(command_t t);
         vertex_out_t o;
         logic signed [31:0] d[16];
         logic signed [31:0] s, c;
         for (int i = 0; i < 4; i++) o.res[i] = 0;
         o.status = ST_OK;
         o.last_out = t.batch_end;
         for (int i = 0; i < 16; i++) d[i] = (i % 5 == 0) ? ONE_Q16 : 32'sd0;
         case (t.kind)
            KIND_XFORM: for (int j = 0; j < 4; j++) o.res[j] = dot_col(t.comp, cur, j);
            KIND_PUSH:
               if (depth_used >= STACK_DEPTH) o.status = ST_OVF;
               else begin
                  for (int i = 0; i < 16; i++) saved[depth_used * 16 + i] = cur[i];
                  depth_used++;
               end
            KIND_POP:
               if (depth_used == 0) o.status = ST_UNF;
               else begin
                  depth_used--;
                  for (int i = 0; i < 16; i++) cur[i] = saved[depth_used * 16 + i];
               end
            KIND_SCALE: begin
               d[0] = t.comp[0]; d[5] = t.comp[1]; d[10] = t.comp[2];
               compose(d);
            end
            KIND_ROTATE: begin
               sin_cos(t.angle_deg, s, c);
               case (t.axis)
                  AXIS_X: begin d[5] = c; d[6] = s; d[9] = -s; d[10] = c; end
                  AXIS_Y: begin d[0] = c; d[2] = -s; d[8] = s; d[10] = c; end
                  AXIS_Z: begin d[0] = c; d[1] = s; d[4] = -s; d[5] = c; end
                  default: ;
               endcase
               compose(d);
            end
            default: ;
         endcase
         return o;
      endfunction
   endclass
endpackage

### bench/tb_matrix_stack_vertex_transform.sv
// testbench top: directed and random command streams with random stalls on both channels
// depends on msvt_pkg, msvt_bench_pkg, msvt_if and matrix_stack_vertex_transform
module tb_matrix_stack_vertex_transform;
   import msvt_pkg::*;
   import msvt_bench_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   msvt_req_if req_chan ();
   msvt_rsp_if rsp_chan ();

   matrix_stack_vertex_transform dut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source)
   );

   always #2 clock = ~clock;

   transform_predictor predictor = new();
   command_t    pending_cmds[$];
   vertex_out_t expected_outs[$];
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  mismatches    = 0;
   int  quiet_cycles  = 0;
   bit  stim_done     = 0;

   initial begin
      req_chan.valid = 0;
      req_chan.kind = 0; req_chan.comp0 = 0; req_chan.comp1 = 0; req_chan.comp2 = 0;
      req_chan.comp3 = 0; req_chan.angle_deg = 0; req_chan.axis = 0; req_chan.batch_end = 0;
      rsp_chan.ready = 0;
   end

   function automatic logic signed [31:0] rand_comp(int mode);
      case (mode % 4)
         0: return $urandom();
         1: return $signed($urandom_range(0, 131072)) - 65536;
         2: return $signed($urandom_range(0, 8388608)) - 4194304;
         default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   function automatic command_t make_cmd(logic [2:0] k, logic signed [31:0] a,
                                         logic signed [31:0] b, logic signed [31:0] c,
                                         logic signed [31:0] w, logic signed [31:0] ang,
                                         logic [1:0] ax, logic be);
      command_t t;
      t.kind = k; t.comp[0] = a; t.comp[1] = b; t.comp[2] = c; t.comp[3] = w;
      t.angle_deg = ang; t.axis = ax; t.batch_end = be;
      return t;
   endfunction

   function automatic command_t rand_cmd();
      command_t t;
      int sel, mode;
      sel = $urandom_range(0, 99);
      mode = $urandom_range(0, 9) < 7 ? 1 : $urandom_range(0, 3);
      t = make_cmd(KIND_XFORM, rand_comp(mode), rand_comp(mode), rand_comp(mode),
                   rand_comp(mode), $urandom(), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1)) t.angle_deg = $signed($urandom_range(0, 1440 * 65536)) -
                                              720 * 65536;
      if (sel < 55) t.kind = KIND_XFORM;
      else if (sel < 67) t.kind = KIND_PUSH;
      else if (sel < 79) t.kind = KIND_POP;
      else if (sel < 87) t.kind = KIND_SCALE;
      else if (sel < 97) t.kind = KIND_ROTATE;
      else t.kind = 3'($urandom_range(5, 7));
      return t;
   endfunction

   // driver
   always @(posedge clock) begin
      command_t t;
      if (reset) begin
         req_chan.valid <= 0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            t = pending_cmds.pop_front();
            req_chan.valid <= 1;
            req_chan.kind <= t.kind;
            req_chan.comp0 <= t.comp[0]; req_chan.comp1 <= t.comp[1];
            req_chan.comp2 <= t.comp[2]; req_chan.comp3 <= t.comp[3];
            req_chan.angle_deg <= t.angle_deg; req_chan.axis <= t.axis;
            req_chan.batch_end <= t.batch_end;
         end else begin
            req_chan.valid <= 0;
         end
      end
   end

   // predictor fed on each accepted request transaction
   always @(posedge clock) begin
      command_t t;
      if (!reset && req_chan.valid && req_chan.ready) begin
         t = make_cmd(req_chan.kind, req_chan.comp0, req_chan.comp1, req_chan.comp2,
                      req_chan.comp3, req_chan.angle_deg, req_chan.axis, req_chan.batch_end);
         expected_outs.push_back(predictor.apply(t));
      end
   end

   // monitor
   always @(posedge clock) begin
      vertex_out_t e;
      logic signed [31:0] got[4];
      bit bad;
      if (reset) begin
         rsp_chan.ready <= 0;
      end else begin
         rsp_chan.ready <= $urandom_range(0, 99) >= recv_idle_pct;
         if (rsp_chan.valid && rsp_chan.ready) begin
            got[0] = rsp_chan.res0; got[1] = rsp_chan.res1;
            got[2] = rsp_chan.res2; got[3] = rsp_chan.res3;
            if (expected_outs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
               e = expected_outs.pop_front();
               bad = rsp_chan.status !== e.status || rsp_chan.last_out !== e.last_out;
               for (int i = 0; i < 4; i++) if (got[i] !== e.res[i]) bad = 1;
               if (bad) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %0d %0d %0d %0d st %0d last %0d, got %0d %0d %0d %0d st %0d last %0d",
                              e.res[0], e.res[1], e.res[2], e.res[3], e.status, e.last_out,
                              got[0], got[1], got[2], got[3], rsp_chan.status,
                              rsp_chan.last_out);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else if (!stim_done || expected_outs.size() > 0) begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic run_phase(int snd, int rcv, int count);
      send_idle_pct = snd;
      recv_idle_pct = rcv;
      for (int i = 0; i < count; i++) pending_cmds.push_back(rand_cmd());
      // keep a few deep stack runs to hit overflow and underflow
      for (int i = 0; i < 22; i++)
         pending_cmds.push_back(make_cmd(KIND_PUSH, 0, 0, 0, 0, 0, 0,
                                         1'($urandom_range(0, 1))));
      for (int i = 0; i < 22; i++)
         pending_cmds.push_back(make_cmd(KIND_POP, 0, 0, 0, 0, 0, 0,
                                         1'($urandom_range(0, 1))));
      while (pending_cmds.size() > 0 || expected_outs.size() > 0) @(posedge clock);
   endtask

   initial begin
      predictor.clear();
      repeat (2) @(posedge clock);
      reset <= 0;
      send_idle_pct = 25; recv_idle_pct = 53;
      pending_cmds.push_back(make_cmd(KIND_XFORM, 32'h7fffffff, 32'h80000000, 32'hffffffff,
                                      65536, 0, AXIS_X, 1));
      pending_cmds.push_back(make_cmd(KIND_POP, 0, 0, 0, 0, 0, AXIS_X, 0));
      pending_cmds.push_back(make_cmd(KIND_PUSH, 0, 0, 0, 0, 0, AXIS_X, 0));
      pending_cmds.push_back(make_cmd(KIND_SCALE, 32'h7fffffff, 32'h80000000, 131072,
                                      32'h12345678, 0, AXIS_X, 1));
      pending_cmds.push_back(make_cmd(KIND_XFORM, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                      32'h80000000, 0, AXIS_X, 0));
      pending_cmds.push_back(make_cmd(KIND_POP, 0, 0, 0, 0, 0, AXIS_X, 1));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 30 * 65536, AXIS_X, 0));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 90 * 65536, AXIS_Y, 1));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, -200 * 65536, AXIS_Z, 0));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 32'h7fffffff, 2'd3, 0));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 32'h80000000, AXIS_Z, 1));
      pending_cmds.push_back(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 270 * 65536 + 1, AXIS_X, 0));
      pending_cmds.push_back(make_cmd(KIND_XFORM, 65536, -65536, 32768, 65536, 0, AXIS_X, 1));
      for (int k = 5; k <= 7; k++)
         pending_cmds.push_back(make_cmd(3'(k), -1, -1, -1, -1, -1, 2'd3, 1));
      pending_cmds.push_back(make_cmd(KIND_XFORM, 0, 0, 0, 0, 0, AXIS_X, 0));
      run_phase(25, 53, 230);
      run_phase(53, 25, 230);
      run_phase(0, 0, 220);
      stim_done = 1;
      repeat (100) @(posedge clock);
      if (mismatches == 0 && expected_outs.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end
endmodule
